// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked through reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ggc_pkg.sv =====
package ggc_pkg;

  // Restoring square root: one result bit per cell, 33-bit radicand.
  localparam int SQRT_STEPS = 17;

  // Length of the arctangent table.
  localparam int ATAN_LEN = 24;

  // Register indexes of the configuration port.
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_GOAL_X        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GOAL_Y        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ARRIVE_TOL    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DISTANCE_GAIN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HEADING_GAIN  = 3'd4;

  // Angles in units of 2^-30 rad.
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

  localparam logic [29:0] ATAN_Q30 [ATAN_LEN] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128
  };

  // Configuration bundle.
  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic [14:0]        arrive_tolerance;
    logic [15:0]        distance_gain;
    logic [15:0]        heading_gain;
  } cfg_t;

  // Data handed from cell to cell.
  typedef struct packed {
    logic               valid;
    logic               arrived;
    logic signed [15:0] heading;
    logic [32:0]        rem;     // square root remainder
    logic [33:0]        root;    // square root partial result
    logic signed [31:0] x;       // CORDIC vector
    logic signed [31:0] y;
    logic signed [33:0] z;       // bearing accumulator, Q30
  } cell_t;

endpackage

// ===== hw/rtl/ggc_front.sv =====
module ggc_front
  import ggc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [15:0] pose_x,
  input  logic signed [15:0] pose_y,
  input  logic signed [15:0] pose_heading,
  input  cfg_t               cfg,
  output cell_t              q
);

  // Stage 0: offset to goal
  logic               v0;
  logic signed [16:0] dx0;
  logic signed [16:0] dy0;
  logic signed [15:0] hd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0  <= in_valid;
      dx0 <= {cfg.goal_x[15], cfg.goal_x} - {pose_x[15], pose_x};
      dy0 <= {cfg.goal_y[15], cfg.goal_y} - {pose_y[15], pose_y};
      hd0 <= pose_heading;
    end
  end

  // Stage 1: squares, tolerance square, CORDIC start vector
  logic signed [33:0] prod_x;
  logic signed [33:0] prod_y;
  logic [29:0]        tol_sq;
  logic signed [16:0] ax;
  logic signed [16:0] ay;
  logic               neg;

  assign prod_x = dx0 * dx0;
  assign prod_y = dy0 * dy0;
  assign tol_sq = cfg.arrive_tolerance * cfg.arrive_tolerance;
  assign neg    = dx0[16];
  assign ax     = neg ? -dx0 : dx0;
  assign ay     = neg ? -dy0 : dy0;

  logic               v1;
  logic [31:0]        sqx1;
  logic [31:0]        sqy1;
  logic [29:0]        tol1;
  logic signed [31:0] x1;
  logic signed [31:0] y1;
  logic signed [33:0] z1;
  logic signed [15:0] hd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1   <= v0;
      sqx1 <= prod_x[31:0];
      sqy1 <= prod_y[31:0];
      tol1 <= tol_sq;
      x1   <= {{3{ax[16]}}, ax, 12'b0};
      y1   <= {{3{ay[16]}}, ay, 12'b0};
      // left half plane starts at +pi or -pi
      z1   <= neg ? (dy0[16] ? -PI_Q30 : PI_Q30) : '0;
      hd1  <= hd0;
    end
  end

  // Stage 2: squared distance and arrival test, head of the cell chain
  logic [32:0] dist_sq;
  assign dist_sq = {1'b0, sqx1} + {1'b0, sqy1};

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid   <= v1;
      q.arrived <= dist_sq <= {3'b0, tol1};
      q.heading <= hd1;
      q.rem     <= dist_sq;
      q.root    <= '0;
      q.x       <= x1;
      q.y       <= y1;
      q.z       <= z1;
    end
  end

endmodule

// ===== hw/rtl/ggc_cell.sv =====
module ggc_cell
  import ggc_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int CORDIC_RUN = 16
)
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t d,
  output cell_t q
);

  localparam bit  SQRT_ON  = IDX < SQRT_STEPS;
  localparam bit  ROT_ON   = IDX < CORDIC_RUN;
  localparam int  SQ_SHIFT = SQRT_ON ? 32 - 2 * IDX : 0;
  localparam logic [33:0] SQ_BIT = 34'd1 << SQ_SHIFT;
  localparam logic [33:0] ATAN   = {4'b0, ATAN_Q30[(IDX < ATAN_LEN) ? IDX : 0]};

  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic [34:0]        trial;
  logic               take;
  cell_t              nxt;

  assign xs    = d.x;
  assign ys    = d.y;
  assign trial = {1'b0, d.root} + {1'b0, SQ_BIT};
  assign take  = {2'b0, d.rem} >= trial;

  // One root bit and one vectoring rotation, each only while IDX is within its step count
  always_comb begin
    nxt = d;
    if (SQRT_ON) begin
      if (take) begin
        nxt.rem  = d.rem - trial[32:0];
        nxt.root = (d.root >> 1) + SQ_BIT;
      end else begin
        nxt.root = d.root >> 1;
      end
    end
    if (ROT_ON) begin
      if (!ys[31]) begin
        nxt.x = xs + (ys >>> IDX);
        nxt.y = ys - (xs >>> IDX);
        nxt.z = d.z + ATAN;
      end else begin
        nxt.x = xs - (ys >>> IDX);
        nxt.y = ys + (xs >>> IDX);
        nxt.z = d.z - ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= nxt;
    end
  end

endmodule

// ===== hw/rtl/ggc_back.sv =====
module ggc_back
  import ggc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cell_t              d,
  input  cfg_t               cfg,
  input  logic               out_ready,
  output logic               en,
  output logic               out_valid,
  output logic signed [15:0] linear_velocity,
  output logic signed [15:0] angular_velocity,
  output logic               arrived
);

  // Stage A: rounded distance, heading error
  logic [33:0]        zr;
  logic signed [16:0] bearing;
  logic [16:0]        dist_rnd;
  logic signed [17:0] err;

  assign zr       = d.z + 34'd65536;
  assign bearing  = zr[33:17];
  assign dist_rnd = d.root[16:0] + {16'b0, ({1'b0, d.rem} > d.root)};
  assign err      = {bearing[16], bearing} - {{2{d.heading[15]}}, d.heading};

  logic               va;
  logic               arr_a;
  logic [16:0]        dist_a;
  logic signed [17:0] err_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va     <= d.valid;
      arr_a  <= d.arrived;
      dist_a <= dist_rnd;
      err_a  <= err;
    end
  end

  // Stage B: gain products
  logic [32:0]        lin_prod;
  logic signed [34:0] ang_prod;

  assign lin_prod = dist_a * cfg.distance_gain;
  assign ang_prod = err_a * $signed({1'b0, cfg.heading_gain});

  logic               vb;
  logic               arr_b;
  logic [32:0]        lin_b;
  logic signed [34:0] ang_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb    <= va;
      arr_b <= arr_a;
      lin_b <= lin_prod;
      ang_b <= ang_prod;
    end
  end

  // Rounding, saturation, arrival override
  logic [33:0]        lin_sum;
  logic [21:0]        lin_sh;
  logic signed [35:0] ang_sum;
  logic signed [20:0] ang_sh;
  logic signed [15:0] lin_res;
  logic signed [15:0] ang_res;

  assign lin_sum = {1'b0, lin_b} + 34'd2048;
  assign lin_sh  = lin_sum[33:12];
  assign ang_sum = {ang_b[34], ang_b} + 36'sd16384;
  assign ang_sh  = ang_sum[35:15];

  always_comb begin
    if (arr_b) begin
      lin_res = '0;
    end else if (lin_sh > 22'd32767) begin
      lin_res = 16'sh7FFF;
    end else begin
      lin_res = lin_sh[15:0];
    end
    if (arr_b) begin
      ang_res = '0;
    end else if (ang_sh > 21'sd32767) begin
      ang_res = 16'sh7FFF;
    end else if (ang_sh < -21'sd32768) begin
      ang_res = -16'sh8000;
    end else begin
      ang_res = ang_sh[15:0];
    end
  end

  // Output register with a skid stage; the chain moves while the skid is empty
  logic               skid_valid;
  logic signed [15:0] skid_lin;
  logic signed [15:0] skid_ang;
  logic               skid_arr;

  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        linear_velocity  <= skid_lin;
        angular_velocity <= skid_ang;
        arrived          <= skid_arr;
        skid_valid       <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid        <= vb;
      linear_velocity  <= lin_res;
      angular_velocity <= ang_res;
      arrived          <= arr_b;
    end else if (vb) begin
      skid_valid <= 1'b1;
      skid_lin   <= lin_res;
      skid_ang   <= ang_res;
      skid_arr   <= arr_b;
    end
  end

endmodule

// ===== hw/rtl/go_to_goal_controller_top.sv =====
// Proportional go-to-goal controller.
// Input channel (in_valid/in_ready): one pose item per handshake, pose_x and
// pose_y in Q6.10, pose_heading in Q3.13 rad. Output channel
// (out_valid/out_ready): one drive command per pose item, in order:
// linear_velocity and angular_velocity in Q6.10, saturated, and arrived,
// which forces both velocities to zero when the goal is within tolerance.
// Configuration: cfg_we writes cfg_data to register cfg_index (goal_x,
// goal_y, arrive_tolerance, distance_gain, heading_gain); write only while
// no item is in flight. Unused indexes are ignored.
// Throughput: one item per cycle while the output is not stalled, with no state between items.
// Pipeline: the front stages, CELLS cells and the back stages lie between accept
// and out_valid, where CELLS is the larger of 17 square root steps and
// CORDIC_STAGES rotation steps (at most 24).
// Stall: a result that reaches the output while it waits is caught by a skid
// stage; in_ready drops with the skid full and the chain holds until it drains.
// Reset: all valid bits clear, configuration registers take their default values.
module go_to_goal_controller_top
  import ggc_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   pose_x,
  input  logic signed [15:0]   pose_y,
  input  logic signed [15:0]   pose_heading,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   linear_velocity,
  output logic signed [15:0]   angular_velocity,
  output logic                 arrived
);

  localparam int CORDIC_RUN = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int CELLS      = (CORDIC_RUN > SQRT_STEPS) ? CORDIC_RUN : SQRT_STEPS;

  // Configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.goal_x           <= 16'sd1024;
      cfg.goal_y           <= 16'sd1024;
      cfg.arrive_tolerance <= 15'd10;
      cfg.distance_gain    <= 16'd4096;
      cfg.heading_gain     <= 16'd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_X:        cfg.goal_x           <= cfg_data;
        REG_GOAL_Y:        cfg.goal_y           <= cfg_data;
        REG_ARRIVE_TOL:    cfg.arrive_tolerance <= cfg_data[14:0];
        REG_DISTANCE_GAIN: cfg.distance_gain    <= cfg_data;
        REG_HEADING_GAIN:  cfg.heading_gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic  en;
  cell_t chain [CELLS+1];

  assign in_ready = en;

  ggc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in_valid),
    .pose_x       (pose_x),
    .pose_y       (pose_y),
    .pose_heading (pose_heading),
    .cfg          (cfg),
    .q            (chain[0])
  );

  // Square root and CORDIC cells
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    ggc_cell #(
      .IDX        (g),
      .CORDIC_RUN (CORDIC_RUN)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (chain[g]),
      .q   (chain[g+1])
    );
  end

  ggc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .d                (chain[CELLS]),
    .cfg              (cfg),
    .out_ready        (out_ready),
    .en               (en),
    .out_valid        (out_valid),
    .linear_velocity  (linear_velocity),
    .angular_velocity (angular_velocity),
    .arrived          (arrived)
  );

endmodule

// ===== hw/rtl/ggc_checker.sv =====
`include "assert_macros.svh"

module ggc_checker
  import ggc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_we,
  input logic [REG_IDX_W-1:0] cfg_index,
  input logic [15:0]          cfg_data,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic signed [15:0]   pose_x,
  input logic signed [15:0]   pose_y,
  input logic signed [15:0]   pose_heading,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic signed [15:0]   linear_velocity,
  input logic signed [15:0]   angular_velocity,
  input logic                 arrived
);

  // A stalled result stays put
  `ASSERT_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(linear_velocity) && $stable(angular_velocity) && $stable(arrived), "stalled item changed")

  // Arrival forces both commands to zero
  `ASSERT_RST(a_arrived_zero, clk, rst, out_valid && arrived |-> linear_velocity == 16'sd0 && angular_velocity == 16'sd0, "arrived with nonzero command")

  // Forward speed is a distance times an unsigned gain
  `ASSERT_RST(a_lin_nonneg, clk, rst, out_valid |-> !linear_velocity[15], "negative linear velocity")

  // Ready drops only after the output stalled
  `ASSERT_RST(a_ready_fall, clk, rst, $fell(in_ready) |-> $past(out_valid && !out_ready), "ready dropped without stall")

  // Reset empties the output and opens the input
  `ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !out_valid && in_ready, "reset left block busy")

endmodule

bind go_to_goal_controller_top ggc_checker u_checker (.*);

// ===== verif/tb_go_to_goal_controller_top.sv =====
`timescale 1ns / 100ps

module tb_go_to_goal_controller_top;
  import ggc_pkg::*;

  localparam int ROT_STAGES   = 16;
  localparam int ROT_RUN      = (ROT_STAGES < 24) ? ROT_STAGES : 24;
  localparam int NUM_PHASES   = 8;
  localparam int TAIL_CYCLES  = 60;
  localparam int LIMIT_CYCLES = 500000;

  // Indexes past the register list; writes there must be ignored.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic signed [15:0] ONE_Q10 = 16'sd1024;
  localparam logic signed [15:0] POS_MAX = 16'sh7FFF;
  localparam logic signed [15:0] POS_MIN = 16'sh8000;
  localparam logic signed [15:0] HEAD_PI = 16'sd25736;

  // Bearing step angles, 2^-30 rad
  localparam longint PI_ANGLE = 64'sd3373259426;
  localparam longint STEP_ANGLE [24] = '{
    843314857, 497837829, 263043837, 133525159,
    67021687,  33543516,  16775851,  8388437,
    4194283,   2097149,   1048576,   524288,
    262144,    131072,    65536,     32768,
    16384,     8192,      4096,      2048,
    1024,      512,       256,       128
  };

  typedef struct packed {
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic               arr;
  } drive_cmd_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;
  typedef enum logic {CHK_MODEL, CHK_FIXED} row_check_t;
  typedef enum logic [1:0] {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    row_kind_t              kind;
    row_check_t             check;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic [15:0]            reg_data;
    logic signed [15:0]     px;
    logic signed [15:0]     py;
    logic signed [15:0]     ph;
    drive_cmd_t             fixed;
  } dir_row_t;

  localparam drive_cmd_t AT_GOAL  = '{16'sd0, 16'sd0, 1'b1};
  localparam drive_cmd_t ZERO_CMD = '{16'sd0, 16'sd0, 1'b0};

  localparam int NUM_DIR_ROWS = 34;
  localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
    // reset config: zero offset, exactly at tolerance, just past it
    '{ROW_ITEM,  CHK_FIXED, REG_GOAL_X, 16'h0000, ONE_Q10, ONE_Q10, HEAD_PI, AT_GOAL},
    '{ROW_ITEM,  CHK_FIXED, REG_GOAL_X, 16'h0000, 16'sd1034, ONE_Q10, -HEAD_PI, AT_GOAL},
    '{ROW_ITEM,  CHK_FIXED, REG_GOAL_X, 16'h0000, ONE_Q10, 16'sd1014, 16'sd0, AT_GOAL},
    '{ROW_ITEM,  CHK_MODEL, REG_GOAL_X, 16'h0000, 16'sd1035, ONE_Q10, 16'sd0, ZERO_CMD},
    // pose extremes, heading outside +/- pi
    '{ROW_ITEM,  CHK_MODEL, REG_GOAL_X, 16'h0000, POS_MIN, POS_MIN, -HEAD_PI, ZERO_CMD},
    '{ROW_ITEM,  CHK_MODEL, REG_GOAL_X, 16'h0000, POS_MAX, POS_MAX, HEAD_PI, ZERO_CMD},
    '{ROW_ITEM,  CHK_MODEL, REG_GOAL_X, 16'h0000, ONE_Q10, 16'sd2048, POS_MAX, ZERO_CMD},
    '{ROW_ITEM,  CHK_MODEL, REG_GOAL_X, 16'h0000, 16'sd0, ONE_Q10, POS_MIN, ZERO_CMD},
    // spare indexes leave the goal where it was
    '{ROW_WRITE, CHK_MODEL, REG_SPARE_5, 16'h0000, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    '{ROW_WRITE, CHK_MODEL, REG_SPARE_6, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    '{ROW_WRITE, CHK_MODEL, REG_SPARE_7, 16'h0000, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    '{ROW_ITEM,  CHK_FIXED, REG_GOAL_X, 16'h0000, ONE_Q10, ONE_Q10, 16'sd0, AT_GOAL},
    '{ROW_ITEM,  CHK_MODEL, REG_GOAL_X, 16'h0000, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    // widest tolerance, bit 15 of the data dropped
    '{ROW_WRITE, CHK_MODEL, REG_ARRIVE_TOL, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    '{ROW_ITEM,  CHK_FIXED, REG_GOAL_X, 16'h0000, ONE_Q10, -16'sd31743, 16'sd0, AT_GOAL},
    '{ROW_ITEM,  CHK_FIXED, REG_GOAL_X, 16'h0000, -16'sd31743, ONE_Q10, 16'sd100, AT_GOAL},
    '{ROW_ITEM,  CHK_MODEL, REG_GOAL_X, 16'h0000, -16'sd22146, -16'sd22146, 16'sd0, ZERO_CMD},
    // zero tolerance
    '{ROW_WRITE, CHK_MODEL, REG_ARRIVE_TOL, 16'h0000, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    '{ROW_ITEM,  CHK_FIXED, REG_GOAL_X, 16'h0000, ONE_Q10, ONE_Q10, 16'sd0, AT_GOAL},
    '{ROW_ITEM,  CHK_MODEL, REG_GOAL_X, 16'h0000, 16'sd1025, ONE_Q10, 16'sd0, ZERO_CMD},
    // goal in a corner, full gains: both commands saturate
    '{ROW_WRITE, CHK_MODEL, REG_GOAL_X, 16'h8000, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    '{ROW_WRITE, CHK_MODEL, REG_GOAL_Y, 16'h7FFF, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    '{ROW_WRITE, CHK_MODEL, REG_DISTANCE_GAIN, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    '{ROW_WRITE, CHK_MODEL, REG_HEADING_GAIN, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    '{ROW_ITEM,  CHK_MODEL, REG_GOAL_X, 16'h0000, POS_MAX, POS_MIN, 16'sd0, ZERO_CMD},
    '{ROW_ITEM,  CHK_FIXED, REG_GOAL_X, 16'h0000, POS_MIN, POS_MAX, -HEAD_PI, AT_GOAL},
    '{ROW_ITEM,  CHK_MODEL, REG_GOAL_X, 16'h0000, POS_MIN, POS_MIN, HEAD_PI, ZERO_CMD},
    // opposite corner, zero gains: commands zero, arrived only at the goal
    '{ROW_WRITE, CHK_MODEL, REG_GOAL_X, 16'h7FFF, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    '{ROW_WRITE, CHK_MODEL, REG_GOAL_Y, 16'h8000, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    '{ROW_WRITE, CHK_MODEL, REG_DISTANCE_GAIN, 16'h0000, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    '{ROW_WRITE, CHK_MODEL, REG_HEADING_GAIN, 16'h0000, 16'sd0, 16'sd0, 16'sd0, ZERO_CMD},
    '{ROW_ITEM,  CHK_FIXED, REG_GOAL_X, 16'h0000, POS_MIN, POS_MAX, HEAD_PI, ZERO_CMD},
    '{ROW_ITEM,  CHK_FIXED, REG_GOAL_X, 16'h0000, POS_MAX, POS_MIN, 16'sd0, AT_GOAL},
    '{ROW_ITEM,  CHK_FIXED, REG_GOAL_X, 16'h0000, 16'sd0, 16'sd0, -HEAD_PI, ZERO_CMD}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [15:0]   pose_x = '0;
  logic signed [15:0]   pose_y = '0;
  logic signed [15:0]   pose_heading = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [15:0]   linear_velocity;
  logic signed [15:0]   angular_velocity;
  logic                 arrived;

  // Shadow of the configuration registers, at their reset values
  logic signed [15:0] set_goal_x = 16'sd1024;
  logic signed [15:0] set_goal_y = 16'sd1024;
  logic [14:0]        set_tol    = 15'd10;
  logic [15:0]        set_dgain  = 16'd4096;
  logic [15:0]        set_hgain  = 16'd16384;

  drive_cmd_t pending_cmds [$];
  drive_cmd_t seen_cmd;
  int         mismatch_count = 0;
  int         result_count = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  rx_mode_t   stall_mode = RX_STEADY;

  go_to_goal_controller_top #(
    .CORDIC_STAGES (ROT_STAGES)
  ) DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .pose_x           (pose_x),
    .pose_y           (pose_y),
    .pose_heading     (pose_heading),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .linear_velocity  (linear_velocity),
    .angular_velocity (angular_velocity),
    .arrived          (arrived)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint sat_q10(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Integer square root, rounded to nearest
  function automatic longint nearest_root(input longint n);
    longint r;
    longint b;
    r = 0;
    for (b = 64'sd1 << 17; b > 0; b = b >> 1) begin
      if ((r + b) * (r + b) <= n) r = r + b;
    end
    if (n - r * r > r) r = r + 1;
    return r;
  endfunction

  // Bearing to goal by vectoring rotations, Q3.13 rad
  function automatic longint goal_bearing(input longint dx, input longint dy);
    longint vx;
    longint vy;
    longint acc;
    longint nx;
    int     k;
    vx = dx;
    vy = dy;
    acc = 0;
    // left half plane: flip the vector and start from +/- pi
    if (vx < 0) begin
      acc = (vy >= 0) ? PI_ANGLE : -PI_ANGLE;
      vx = -vx;
      vy = -vy;
    end
    vx = vx * 4096;
    vy = vy * 4096;
    for (k = 0; k < ROT_RUN; k++) begin
      if (vy >= 0) begin
        nx  = vx + (vy >>> k);
        vy  = vy - (vx >>> k);
        acc = acc + STEP_ANGLE[k];
      end else begin
        nx  = vx - (vy >>> k);
        vy  = vy + (vx >>> k);
        acc = acc - STEP_ANGLE[k];
      end
      vx = nx;
    end
    return (acc + 65536) >>> 17;
  endfunction

  function automatic drive_cmd_t predict_drive(input logic signed [15:0] px,
                                               input logic signed [15:0] py,
                                               input logic signed [15:0] ph);
    longint     dx;
    longint     dy;
    longint     sq;
    longint     dist_rnd;
    longint     err;
    drive_cmd_t c;
    dx = longint'(set_goal_x) - longint'(px);
    dy = longint'(set_goal_y) - longint'(py);
    sq = dx * dx + dy * dy;
    if (sq <= longint'(set_tol) * longint'(set_tol)) begin
      c = AT_GOAL;
    end else begin
      dist_rnd = nearest_root(sq);
      err      = goal_bearing(dx, dy) - longint'(ph);
      c.lin    = 16'(sat_q10((dist_rnd * longint'(set_dgain) + 2048) >>> 12));
      c.ang    = 16'(sat_q10((err * longint'(set_hgain) + 16384) >>> 15));
      c.arr    = 1'b0;
    end
    return c;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result %0d: %s", $time, result_count, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("result with no item waiting");
      end else begin
        seen_cmd = pending_cmds.pop_front();
        if (linear_velocity !== seen_cmd.lin)
          report_mismatch($sformatf("linear_velocity %0d, expected %0d",
                                    linear_velocity, seen_cmd.lin));
        if (angular_velocity !== seen_cmd.ang)
          report_mismatch($sformatf("angular_velocity %0d, expected %0d",
                                    angular_velocity, seen_cmd.ang));
        if (arrived !== seen_cmd.arr)
          report_mismatch($sformatf("arrived %b, expected %b", arrived, seen_cmd.arr));
      end
      result_count++;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Output stalls: a pattern is drawn at random whenever the low byte of cycle_count is zero
  always @(posedge clk) begin
    if (cycle_count[7:0] == 8'd0) stall_mode = rx_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      RX_STEADY:   out_ready <= 1'b1;
      RX_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:    out_ready <= ($urandom_range(0, 1) != 0);
      RX_PERIODIC: out_ready <= ((cycle_count % 7) >= 3);
      default:     out_ready <= 1'b1;
    endcase
  end

  // ---------------------------------------------------------------- driving

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_GOAL_X:        set_goal_x = data;
      REG_GOAL_Y:        set_goal_y = data;
      REG_ARRIVE_TOL:    set_tol    = data[14:0];
      REG_DISTANCE_GAIN: set_dgain  = data;
      REG_HEADING_GAIN:  set_hgain  = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every outstanding command is back
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic send_pose(input logic signed [15:0] px, input logic signed [15:0] py,
                           input logic signed [15:0] ph, input logic use_fixed,
                           input drive_cmd_t fixed_cmd);
    int gap;
    // bursts of items with random gaps in between
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    pose_x       <= px;
    pose_y       <= py;
    pose_heading <= ph;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    pending_cmds.push_back(use_fixed ? fixed_cmd : predict_drive(px, py, ph));
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [15:0] clamp_q10(input longint v);
    return 16'(sat_q10(v));
  endfunction

  function automatic logic [15:0] pick_goal();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN;
      2: return 16'(int'($urandom_range(0, 8192)) - 4096);
      default: return ONE_Q10;
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 16384));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_edge(input logic signed [15:0] goal);
    case ($urandom_range(0, 3))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return 16'sd0;
      default: return goal;
    endcase
  endfunction

  initial begin : stimulus
    int                 r;
    int                 phase;
    int                 n;
    int                 k;
    int                 hold_at;
    int                 spread;
    longint             ofs;
    logic [14:0]        tol;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] ph;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (r = 0; r < NUM_DIR_ROWS; r++) begin
      if (DIR_ROWS[r].kind == ROW_WRITE) begin
        wait_drained();
        reg_write(DIR_ROWS[r].reg_idx, DIR_ROWS[r].reg_data);
      end else begin
        send_pose(DIR_ROWS[r].px, DIR_ROWS[r].py, DIR_ROWS[r].ph,
                  DIR_ROWS[r].check == CHK_FIXED, DIR_ROWS[r].fixed);
      end
    end

    // random phases, fresh settings each time
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      reg_write(REG_GOAL_X, pick_goal());
      reg_write(REG_GOAL_Y, pick_goal());
      case ($urandom_range(0, 4))
        0: tol = 15'd0;
        1: tol = 15'h7FFF;
        2: tol = 15'($urandom_range(0, 64));
        3: tol = 15'($urandom);
        default: tol = 15'($urandom_range(0, 2048));
      endcase
      // bit 15 carries junk that the register must drop
      reg_write(REG_ARRIVE_TOL, {1'($urandom_range(0, 1)), tol});
      reg_write(REG_DISTANCE_GAIN, pick_gain());
      reg_write(REG_HEADING_GAIN, pick_gain());

      n = $urandom_range(180, 230);
      hold_at = $urandom_range(20, n - 20);
      for (k = 0; k < n; k++) begin
        if (k == hold_at) wait_drained();
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            px = 16'($urandom);
            py = 16'($urandom);
          end
          // around the goal, across the tolerance circle
          4, 5, 6: begin
            spread = int'(set_tol) + 16;
            px = clamp_q10(longint'(set_goal_x) + longint'($urandom_range(0, 2 * spread)) - spread);
            py = clamp_q10(longint'(set_goal_y) + longint'($urandom_range(0, 2 * spread)) - spread);
          end
          7: begin
            px = pick_edge(set_goal_x);
            py = pick_edge(set_goal_y);
          end
          // on an axis through the goal
          8: begin
            if ($urandom_range(0, 1) != 0) begin
              px = set_goal_x;
              py = 16'($urandom);
            end else begin
              px = 16'($urandom);
              py = set_goal_y;
            end
          end
          // right at the tolerance or one past it
          default: begin
            ofs = longint'(set_tol) + longint'($urandom_range(0, 1));
            if ($urandom_range(0, 1) != 0) ofs = -ofs;
            px = clamp_q10(longint'(set_goal_x) + ofs);
            py = set_goal_y;
          end
        endcase
        if ($urandom_range(0, 99) < 85) ph = 16'(int'($urandom_range(0, 51472)) - 25736);
        else ph = 16'($urandom);
        send_pose(px, py, ph, 1'b0, ZERO_CMD);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
